[design/xtea_pkg.sv]
`default_nettype none

package xtea_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CYCLES  = 32;
    localparam int unsigned ROUNDS  = 2 * CYCLES;
    localparam int unsigned KEYS    = 4;
    localparam int unsigned KIDX_W  = $clog2(KEYS);
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KIDX_W-1:0] t_kidx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef t_word [KEYS-1:0] t_key;

    typedef struct packed {
        t_word first_half;
        t_word second_half;
    } t_blk;

    localparam t_word DELTA = 32'h9e37_79b9;

    localparam t_cfg_idx CFG_KEY0 = 3'd0;
    localparam t_cfg_idx CFG_KEY1 = 3'd1;
    localparam t_cfg_idx CFG_KEY2 = 3'd2;
    localparam t_cfg_idx CFG_KEY3 = 3'd3;
    localparam t_cfg_idx CFG_MODE = 3'd4;

    // n * delta modulo 2^32
    function automatic t_word sum_at(input int unsigned n);
        t_word f_prod;
        f_prod = DELTA * WORD_W'(n);
        return f_prod;
    endfunction

    function automatic t_word mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

[design/xtea_stream_if.sv]
`default_nettype none

interface xtea_stream_if import xtea_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word first_half;
    t_word second_half;

    modport source (output valid, output first_half, output second_half, input ready);
    modport sink   (input valid, input first_half, input second_half, output ready);
endinterface

`default_nettype wire

[design/xtea_block_cipher_top.sv]
// XTEA block cipher, one round per pipeline stage, 64 stages.
// Each block passes through the round registers and then the output queue.
// Throughput: one block per cycle; a stalled output freezes the pipeline
// once the two-entry output queue is full.
// Reset (synchronous, active low) clears key, mode and all valid bits.
`default_nettype none

module xtea_block_cipher_top import xtea_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_idx,
    input  wire t_word    i_cfg_data,
    xtea_stream_if.sink   i_in,
    xtea_stream_if.source o_out
);

    t_key r_key;
    logic r_decrypt;
    logic en;
    logic full;
    logic stg_valid [ROUNDS+1];
    t_blk stg_blk   [ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                CFG_MODE: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en         = !full;
    assign i_in.ready = en;

    assign stg_valid[0]          = i_in.valid;
    assign stg_blk[0].first_half  = i_in.first_half;
    assign stg_blk[0].second_half = i_in.second_half;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        localparam int unsigned STEP = (g + 1) / 2;
        xtea_round u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (stg_valid[g]),
            .i_blk     (stg_blk[g]),
            .i_key     (r_key),
            .i_decrypt (r_decrypt),
            .i_phase   (1'(g % 2)),
            .i_enc_sum (sum_at(STEP)),
            .i_dec_sum (sum_at(CYCLES - STEP)),
            .o_valid   (stg_valid[g+1]),
            .o_blk     (stg_blk[g+1])
        );
    end

    xtea_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[ROUNDS] && en),
        .i_blk   (stg_blk[ROUNDS]),
        .o_full  (full),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[design/xtea_round.sv]
`default_nettype none

module xtea_round import xtea_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_blk i_blk,
    input  wire t_key i_key,
    input  wire logic i_decrypt,
    input  wire logic i_phase,
    input  wire t_word i_enc_sum,
    input  wire t_word i_dec_sum,
    output logic      o_valid,
    output t_blk      o_blk
);

    logic  r_valid;
    t_blk  r_blk;
    t_blk  n_blk;
    logic  upd_second;
    t_word sum;
    t_kidx kidx;
    t_word src;
    t_word dst;
    t_word f;
    t_word res;

    always_comb begin
        upd_second = i_phase ^ i_decrypt;
        sum        = i_decrypt ? i_dec_sum : i_enc_sum;
        kidx       = upd_second ? sum[12:11] : sum[1:0];
        src        = upd_second ? i_blk.first_half : i_blk.second_half;
        dst        = upd_second ? i_blk.second_half : i_blk.first_half;
        f          = mix(src) ^ (sum + i_key[kidx]);
        res        = i_decrypt ? (dst - f) : (dst + f);
        n_blk      = i_blk;
        if (upd_second) begin
            n_blk.second_half = res;
        end else begin
            n_blk.first_half = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

`default_nettype wire

[design/xtea_outq.sv]
`default_nettype none

module xtea_outq import xtea_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_blk i_blk,
    output logic      o_full,
    xtea_stream_if.source o_out
);

    t_blk       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign push = i_valid;
    assign pop  = o_out.valid && o_out.ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_blk;
        end
    end

    assign o_full            = r_count[1];
    assign o_out.valid       = r_count != 2'd0;
    assign o_out.first_half  = r_mem[r_rd_ptr].first_half;
    assign o_out.second_half = r_mem[r_rd_ptr].second_half;

endmodule

`default_nettype wire
